@@ design/assert_macros.svh @@
// Assertion macros used by the top level of the reply decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/hsrd_pkg.sv @@
// Types, constants and the CRC-8 step shared by the reply decoder modules.
package hsrd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic KIND_MEAS   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic RES_OK      = 1'b0;
  localparam logic RES_CRC_ERR = 1'b1;

  localparam logic [2:0] POS_HIGH0 = 3'd0;
  localparam logic [2:0] POS_LOW0  = 3'd1;
  localparam logic [2:0] POS_CRC0  = 3'd2;
  localparam logic [2:0] POS_HIGH1 = 3'd3;
  localparam logic [2:0] POS_LOW1  = 3'd4;
  localparam logic [2:0] POS_CRC1  = 3'd5;

  localparam int HSRD_QUEUE_DEPTH = 2;

  localparam int TEMP_W = 15;
  localparam int HUM_W  = 14;
  localparam int STAT_W = 16;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  typedef struct packed {
    logic        err;
    logic        kind;
    logic [15:0] raw_a;
    logic [15:0] raw_b;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ design/hsrd_front.sv @@
// Front end: tracks byte position, checks CRC per word and queues finished frames.
module hsrd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // rx_byte
  input  logic [1:0]          s_tuser,   // [0] action, [1] frame_start
  input  hsrd_pkg::queue_stat_t q_stat,
  output logic                push,
  output hsrd_pkg::job_t      push_job
);
  import hsrd_pkg::*;

  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  crc_accum, crc_accum_next;
  logic [7:0]  word_high, word_high_next;
  logic [7:0]  word_low, word_low_next;
  logic [15:0] first_raw, first_raw_next;
  logic        error_seen, error_seen_next;
  logic        kind_latched, kind_latched_next;

  logic        accept;
  logic [2:0]  pos;
  logic        kind;
  logic        err_in;
  logic [7:0]  crc_in;
  logic [15:0] word;
  logic        err_out;
  logic        frame_end;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    pos    = s_tuser[1] ? POS_HIGH0 : byte_position;
    kind   = s_tuser[1] ? s_tuser[0] : kind_latched;
    err_in = (pos == POS_HIGH0) ? 1'b0 : error_seen;
    crc_in = (pos == POS_HIGH0) ? CRC_INIT : crc_accum;
    word   = {word_high, word_low};

    word_high_next     = word_high;
    word_low_next      = word_low;
    first_raw_next     = first_raw;
    crc_accum_next     = crc_in;
    err_out            = err_in;
    frame_end          = 1'b0;

    case (pos)
      POS_HIGH0, POS_HIGH1: begin
        word_high_next = s_tdata;
        crc_accum_next = crc8_update(crc_in, s_tdata);
      end
      POS_LOW0, POS_LOW1: begin
        word_low_next  = s_tdata;
        crc_accum_next = crc8_update(crc_in, s_tdata);
      end
      default: begin
        // A CRC byte closes a word.
        err_out        = err_in || (crc_in != s_tdata);
        crc_accum_next = CRC_INIT;
        if (pos == POS_CRC0) begin
          first_raw_next = word;
        end
        frame_end = (kind == KIND_STATUS) ? (pos >= POS_CRC0) : (pos >= POS_CRC1);
      end
    endcase

    error_seen_next    = err_out;
    kind_latched_next  = kind;
    byte_position_next = frame_end ? POS_HIGH0 : pos + 3'd1;

    push_job.err   = err_out;
    push_job.kind  = kind;
    push_job.raw_a = first_raw_next;
    push_job.raw_b = word;
  end

  assign push = accept && frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HIGH0;
      crc_accum     <= CRC_INIT;
      word_high     <= '0;
      word_low      <= '0;
      first_raw     <= '0;
      error_seen    <= 1'b0;
      kind_latched  <= KIND_MEAS;
    end else if (accept) begin
      byte_position <= byte_position_next;
      crc_accum     <= crc_accum_next;
      word_high     <= word_high_next;
      word_low      <= word_low_next;
      first_raw     <= first_raw_next;
      error_seen    <= error_seen_next;
      kind_latched  <= kind_latched_next;
    end
  end

endmodule

@@ design/hsrd_queue.sv @@
// Short queue of finished frames between the front end and the converter.
module hsrd_queue #(
  parameter int QUEUE_DEPTH = hsrd_pkg::HSRD_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  hsrd_pkg::job_t        push_job,
  input  logic                  pop,
  output hsrd_pkg::job_t        pop_job,
  output hsrd_pkg::queue_stat_t stat
);
  import hsrd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_job    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/hsrd_back.sv @@
// Back end: scales raw measurement words to centi units, passes status words, in two stages and holds the result item.
module hsrd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  hsrd_pkg::queue_stat_t q_stat,
  input  hsrd_pkg::job_t        pop_job,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,  // temperature_centi, humidity_centi, status_word
  output logic [1:0]            m_tuser   // [0] result_code, [1] frame_kind
);
  import hsrd_pkg::*;

  // Stage one: products.
  logic        s1_valid;
  logic        s1_err;
  logic        s1_kind;
  logic [15:0] s1_status;
  logic [30:0] s1_tprod;
  logic [29:0] s1_hprod;

  // Output register.
  logic              out_valid;
  logic              out_err;
  logic              out_kind;
  logic [TEMP_W-1:0] out_temp;
  logic [HUM_W-1:0]  out_hum;
  logic [STAT_W-1:0] out_status;

  logic        out_load;
  logic        s1_ready;
  logic [16:0] t_sum, h_sum;
  logic [14:0] t_quot;
  logic [13:0] h_quot;
  logic        meas_ok, status_ok;

  assign out_load = s1_valid && (!out_valid || m_tready);
  assign s1_ready = !s1_valid || out_load;
  assign pop      = !q_stat.empty && s1_ready;

  // floor(x / 65535) with x = a*65536 + b equals a + ((a + b) >= 65535),
  // since a + b stays below twice the divisor here.
  always_comb begin
    t_sum     = {2'b00, s1_tprod[30:16]} + {1'b0, s1_tprod[15:0]};
    h_sum     = {3'b000, s1_hprod[29:16]} + {1'b0, s1_hprod[15:0]};
    t_quot    = s1_tprod[30:16] + 15'(t_sum >= FULL_SCALE);
    h_quot    = s1_hprod[29:16] + 14'(h_sum >= FULL_SCALE);
    meas_ok   = !s1_err && (s1_kind == KIND_MEAS);
    status_ok = !s1_err && (s1_kind == KIND_STATUS);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_err    <= pop_job.err;
      s1_kind   <= pop_job.kind;
      s1_status <= pop_job.raw_a;
      s1_tprod  <= {15'd0, pop_job.raw_a} * {16'd0, TEMP_SCALE};
      s1_hprod  <= {14'd0, pop_job.raw_b} * {16'd0, HUM_SCALE};
    end
    if (out_load) begin
      out_err    <= s1_err;
      out_kind   <= s1_kind;
      out_temp   <= meas_ok ? (t_quot - TEMP_OFFSET) : '0;
      out_hum    <= meas_ok ? h_quot : '0;
      out_status <= status_ok ? s1_status : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pop;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_status, out_hum, out_temp};
  assign m_tuser  = {out_kind, out_err};

endmodule

@@ design/humidity_sensor_reply_decoder.sv @@
// Top level of the sensor reply decoder: CRC-checking front end, frame queue, converter.
//
//  channel  | dir | tdata                                 | tuser
//  s_*      | in  | [7:0] rx_byte                         | [0] action, [1] frame_start
//  m_*      | out | [14:0] temperature_centi, [28:15]     | [0] result_code, [1] frame_kind
//           |     | humidity_centi, [44:29] status_word   |
//
// One byte is taken every cycle while s_tready is high; each word's CRC is checked
// as its CRC byte arrives. A result passes the queue, stage one and output register.
// s_tready drops only while the frame queue is full, i.e. results pile up behind a
// stalled master side; the output register keeps the two sides apart.
// Synchronous reset clears position, CRC state, queue and valid flags.
`include "assert_macros.svh"

module humidity_sensor_reply_decoder #(
  parameter int QUEUE_DEPTH = hsrd_pkg::HSRD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic [1:0]  s_tuser,   // [0] action, [1] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // temperature_centi, humidity_centi, status_word, zero fill
  output logic [1:0]  m_tuser    // [0] result_code, [1] frame_kind
);
  import hsrd_pkg::*;

  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        pop_job;
  queue_stat_t q_stat;

  hsrd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  hsrd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  hsrd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop_job  (pop_job),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `ASSERT_ALWAYS(a_queue_no_overflow, clk, rst, !(push && q_stat.full), "frame pushed into a full queue")
  `ASSERT_ALWAYS(a_queue_stat_sane, clk, rst, !(q_stat.full && q_stat.empty), "queue both full and empty")
  `ASSERT_IMPLIES(a_error_zero, clk, rst, m_tvalid && (m_tuser[0] == RES_CRC_ERR), m_tdata == 48'd0, "error result carries values")
  `ASSERT_IMPLIES(a_status_no_meas, clk, rst, m_tvalid && (m_tuser[1] == KIND_STATUS), m_tdata[28:0] == 29'd0, "status result carries measurement values")

endmodule

@@ tb/humidity_sensor_reply_decoder_test.sv @@
// Self-checking testbench for the sensor reply decoder: CRC checks, frame handling, conversions.
module humidity_sensor_reply_decoder_test;
  import hsrd_pkg::*;

  localparam int ITEM_TARGET    = 1300;
  localparam int IDLE_LIMIT     = 3000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct packed {
    logic        err;
    logic        kind;
    logic [14:0] temp_c;
    logic [13:0] hum_c;
    logic [15:0] status;
  } reading_t;

  class reply_scoreboard;
    logic [7:0]  crc_run;
    logic [2:0]  pos;
    logic [7:0]  word_hi;
    logic [7:0]  word_lo;
    logic [15:0] first_word;
    logic        err_seen;
    logic        kind;
    reading_t    pending_readings[$];
    int          mismatches;
    int          readings_checked;
    int          error_readings;
    int          status_readings;

    function new();
      crc_run    = CRC_INIT;
      pos        = POS_HIGH0;
      word_hi    = 8'h00;
      word_lo    = 8'h00;
      first_word = 16'h0000;
      err_seen   = 1'b0;
      kind       = KIND_MEAS;
    endfunction

    // MSB-first CRC-8, one input bit at a time.
    static function logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return c;
    endfunction

    static function logic [7:0] word_crc(input logic [15:0] w);
      return crc_step(crc_step(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    // Advances the decoder state by one accepted byte and queues any finished reading.
    function void note_byte(input logic [7:0] b, input logic act, input logic st);
      logic [15:0] word;
      logic [31:0] tv;
      logic [31:0] tc;
      reading_t    r;
      if (st) begin
        pos  = POS_HIGH0;
        kind = act;
      end
      if (pos == POS_HIGH0) begin
        err_seen = 1'b0;
        crc_run  = CRC_INIT;
      end
      case (pos)
        POS_HIGH0, POS_HIGH1: begin
          word_hi = b;
          crc_run = crc_step(crc_run, b);
        end
        POS_LOW0, POS_LOW1: begin
          word_lo = b;
          crc_run = crc_step(crc_run, b);
        end
        default: begin
          word = {word_hi, word_lo};
          if (crc_run != b) err_seen = 1'b1;
          crc_run = CRC_INIT;
          if (pos == POS_CRC0) first_word = word;
          if (pos == POS_CRC1 || kind == KIND_STATUS) begin
            r = '0;
            r.err  = err_seen ? RES_CRC_ERR : RES_OK;
            r.kind = kind;
            if (!err_seen) begin
              if (kind == KIND_STATUS) begin
                r.status = first_word;
              end else begin
                tv = (32'd17500 * {16'd0, first_word}) / 32'd65535;
                tc = tv - 32'd4500;
                r.temp_c = tc[14:0];
                tv = (32'd10000 * {16'd0, word}) / 32'd65535;
                r.hum_c = tv[13:0];
              end
            end
            pending_readings.push_back(r);
            pos = POS_HIGH0;
            return;
          end
        end
      endcase
      pos = pos + 3'd1;
    endfunction

    task report(input string what, input logic [47:0] got, input logic [47:0] want);
      if (mismatches < 40)
        $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
    endtask

    task check_reading(input logic [47:0] data, input logic [1:0] user);
      reading_t e;
      if (pending_readings.size() == 0) begin
        report("unexpected reading", {user, data[45:0]}, '0);
        return;
      end
      e = pending_readings.pop_front();
      readings_checked++;
      if (e.err == RES_CRC_ERR) error_readings++;
      if (e.kind == KIND_STATUS) status_readings++;
      if (user[0] !== e.err) report("result_code", 48'(user[0]), 48'(e.err));
      if (user[1] !== e.kind) report("frame_kind", 48'(user[1]), 48'(e.kind));
      if (data[14:0] !== e.temp_c)
        report("temperature_centi", 48'(data[14:0]), 48'(e.temp_c));
      if (data[28:15] !== e.hum_c)
        report("humidity_centi", 48'(data[28:15]), 48'(e.hum_c));
      if (data[44:29] !== e.status)
        report("status_word", 48'(data[44:29]), 48'(e.status));
      if (data[47:45] !== 3'b000) report("tdata fill", 48'(data[47:45]), 48'd0);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // rx_byte
  logic [1:0]  s_tuser;   // [0] action, [1] frame_start
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // [14:0] temperature, [28:15] humidity, [44:29] status word
  logic [1:0]  m_tuser;   // [0] result_code, [1] frame_kind

  reply_scoreboard sb = new();
  int   bytes_sent;
  int   idle_cycles;
  logic calm;
  logic hold_rx;

  humidity_sensor_reply_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : $urandom_range(65527, 65534));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reading(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when the sender asks for it.
  initial begin : rx_side
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  // Entered and left at a falling edge; valid stays high when no gap follows.
  task automatic send_byte(input logic [7:0] b, input logic act, input logic st);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {st, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b, act, st);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends up to cut bytes of a frame; a corrupted CRC byte is never equal to the right one.
  task automatic send_frame(input logic knd, input logic [15:0] w0, input logic [15:0] w1,
                            input bit bad0, input bit bad1, input bit st, input int cut);
    logic [7:0] bytes [6];
    int         len;
    logic       act;
    bytes[0] = w0[15:8];
    bytes[1] = w0[7:0];
    bytes[2] = reply_scoreboard::word_crc(w0) ^ (bad0 ? 8'($urandom_range(1, 255)) : 8'h00);
    bytes[3] = w1[15:8];
    bytes[4] = w1[7:0];
    bytes[5] = reply_scoreboard::word_crc(w1) ^ (bad1 ? 8'($urandom_range(1, 255)) : 8'h00);
    len = (knd == KIND_STATUS) ? 3 : 6;
    if (cut < len) len = cut;
    for (int i = 0; i < len; i++) begin
      act = (i == 0 && st) ? knd : 1'($urandom_range(0, 1));
      send_byte(bytes[i], act, (i == 0) ? st : 1'b0);
    end
  endtask

  task automatic wait_all_readings();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() > 0) @(negedge clk);
  endtask

  initial begin : tx_side
    logic kind_now;
    logic last_kind;
    bit   need_start;
    bit   with_start;
    bit   hold_done;
    bit   pause_done;
    int   r;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = 8'h00;
    s_tuser    = 2'b00;
    calm       = 1'b0;
    hold_rx    = 1'b0;
    bytes_sent = 0;
    hold_done  = 0;
    pause_done = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Before any start mark the bytes form a measurement, and action is ignored.
    send_frame(KIND_MEAS, 16'h0000, 16'hFFFF, 0, 0, 0, 6);
    send_frame(KIND_STATUS, 16'hFFFF, 16'h0000, 0, 0, 1, 6);
    // Bytes after a finished frame continue with the same kind.
    send_frame(KIND_STATUS, 16'h0000, 16'h0000, 1, 0, 0, 6);
    send_frame(KIND_MEAS, 16'hFFFF, 16'h0000, 0, 1, 1, 6);
    send_frame(KIND_MEAS, 16'h8000, 16'h8000, 1, 0, 1, 6);
    // A start mark in mid frame drops the partial frame.
    send_frame(KIND_MEAS, 16'h1234, 16'h5678, 0, 0, 1, 2);
    send_frame(KIND_STATUS, 16'h8000, 16'h0000, 0, 0, 1, 6);
    last_kind  = KIND_STATUS;
    need_start = 0;

    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      if (!hold_done && bytes_sent >= 400) begin
        hold_done = 1;
        hold_rx   = 1'b1;
      end
      if (!pause_done && bytes_sent >= 800) begin
        pause_done = 1;
        wait_all_readings();
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        kind_now = 1'($urandom_range(0, 1));
        send_frame(kind_now, pick_word(), pick_word(), 0, 0, 1,
                   $urandom_range(1, (kind_now == KIND_STATUS) ? 2 : 5));
        need_start = 1;
      end else if (r < 12) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        need_start = 1;
      end else begin
        with_start = need_start || ($urandom_range(0, 5) != 0);
        kind_now   = with_start ? 1'($urandom_range(0, 1)) : last_kind;
        send_frame(kind_now, pick_word(), pick_word(), $urandom_range(0, 9) == 0,
                   $urandom_range(0, 9) == 0, with_start, 6);
        last_kind  = kind_now;
        need_start = 0;
      end
    end

    wait_all_readings();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d reply bytes; checked %0d readings, %0d of them status frames.",
             bytes_sent, sb.readings_checked, sb.status_readings);
    $display("Readings flagged with CRC errors: %0d; mismatches: %0d.",
             sb.error_readings, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
